@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked implication check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ sv/lxfe_pkg.sv @@
// ---------------------------------------------------------------------------
// lxfe_pkg
// Types and codes of the lazy x86 status-flag unit.
// ---------------------------------------------------------------------------
package lxfe_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned COND_W  = 4;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned SHAMT_W = 5;    // shift count is second & 0x1F

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_STORE = 2'd0,
        REQ_COND  = 2'd1,
        REQ_FLAGS = 2'd2,
        REQ_NOP   = 2'd3
    } req_type_t;

    // Recorded operation kinds; anything else is unknown
    typedef enum logic [KIND_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_CMP  = 4'd2,
        OP_AND  = 4'd3,
        OP_OR   = 4'd4,
        OP_XOR  = 4'd5,
        OP_TEST = 4'd6,
        OP_SHL  = 4'd7,
        OP_SHR  = 4'd8,
        OP_SAR  = 4'd9
    } op_kind_t;

    // Condition groups (cond_code[3:1]); cond_code[0] inverts the test
    typedef enum logic [2:0] {
        CC_O  = 3'd0,
        CC_B  = 3'd1,
        CC_Z  = 3'd2,
        CC_BE = 3'd3,
        CC_S  = 3'd4,
        CC_P  = 3'd5,
        CC_L  = 3'd6,
        CC_LE = 3'd7
    } cond_grp_t;

    // Status flags, bit 0 CF up to bit 5 OF
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } flags_t;

    // Recorded operation awaiting flag derivation
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
        logic [KIND_W-1:0] kind;
    } saved_op_t;

endpackage

@@ sv/lxfe_flag_calc.sv @@
// ---------------------------------------------------------------------------
// lxfe_flag_calc
// Derives the six status flags from a recorded operation.
// ---------------------------------------------------------------------------
module lxfe_flag_calc
    import lxfe_pkg::*;
(
    input  saved_op_t op,
    output flags_t    flags
);

    logic [DATA_W-1:0]  r;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
    logic [SHAMT_W-1:0] cnt;
    logic [SHAMT_W-1:0] shl_idx;
    logic [SHAMT_W-1:0] shr_idx;
    logic               cnt_nz;
    logic               cnt_one;
    logic               aux;
    logic               cf;
    logic               of;
    logic               af;

    assign r = op.result;
    assign a = op.first;
    assign b = op.second;

    // shift count and the position of the last bit shifted out
    assign cnt     = b[SHAMT_W-1:0];
    assign cnt_nz  = (cnt != '0);
    assign cnt_one = (cnt == SHAMT_W'(1));
    assign shl_idx = SHAMT_W'(~cnt + SHAMT_W'(1));   // 32 - cnt
    assign shr_idx = cnt - SHAMT_W'(1);
    assign aux     = a[4] ^ b[4] ^ r[4];

    // carry, overflow and adjust by operation kind
    always_comb
    begin
        cf = 1'b0;
        of = 1'b0;
        af = 1'b0;
        unique case (op.kind)
            OP_ADD:
            begin
                cf = (r < a);
                of = (a[DATA_W-1] == b[DATA_W-1]) && (r[DATA_W-1] != a[DATA_W-1]);
                af = aux;
            end
            OP_SUB, OP_CMP:
            begin
                cf = (a < b);
                of = (a[DATA_W-1] != b[DATA_W-1]) && (r[DATA_W-1] != a[DATA_W-1]);
                af = aux;
            end
            OP_SHL:
            begin
                cf = cnt_nz & a[shl_idx];
                of = cnt_one & (r[DATA_W-1] ^ a[shl_idx]);
            end
            OP_SHR:
            begin
                cf = cnt_nz & a[shr_idx];
                of = cnt_one & a[DATA_W-1];
            end
            OP_SAR:
            begin
                cf = cnt_nz & a[shr_idx];
            end
            default:
            begin
                // logic kinds and unknown kinds leave CF, OF, AF clear
                cf = 1'b0;
            end
        endcase
    end

    // flag vector: result-based PF, ZF, SF plus CF, AF, OF from above
    always_comb
    begin
        flags    = '0;
        flags.cf = cf;
        flags.pf = ~^r[7:0];
        flags.af = af;
        flags.zf = (r == '0);
        flags.sf = r[DATA_W-1];
        flags.of = of;
    end

endmodule

@@ sv/lazy_x86_flag_evaluator_unit.sv @@
// ---------------------------------------------------------------------------
// lazy_x86_flag_evaluator_unit
// Lazy x86 status-flag unit: records operations, derives flags on demand.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries req_type, the operation
//   to record (op_result, first_source, second_source, op_kind) and the
//   condition code. A store request records the operation and marks the
//   flags pending; a condition or flags request derives the flags first if
//   they are pending, and a condition request also returns cond_true.
//   Response channel (rsp_valid/rsp_ready) returns one item per request:
//   cond_true plus the six flags as held after the request.
//   A request passes the input register, then the result register, before
//   its response is valid. Throughput: one request per cycle while the
//   receiver takes responses; flag derivation and condition test fit in
//   the single stage between the two registers.
//   Reset clears the recorded operation's pending mark and all flags;
//   both pipeline registers come up empty.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; req_ready drops once both are occupied.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lazy_x86_flag_evaluator_unit
    import lxfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [DATA_W-1:0] op_result,
    input  logic [DATA_W-1:0] first_source,
    input  logic [DATA_W-1:0] second_source,
    input  logic [KIND_W-1:0] op_kind,
    input  logic [COND_W-1:0] cond_code,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic              cond_true,
    output logic              carry_flag,
    output logic              parity_flag,
    output logic              adjust_flag,
    output logic              zero_flag,
    output logic              sign_flag,
    output logic              overflow_flag
);

    // input stage
    logic              in_valid_reg;
    req_type_t         req_type_reg;
    saved_op_t         req_op_reg;
    logic [COND_W-1:0] cond_code_reg;

    // architectural state
    saved_op_t         saved_reg;
    saved_op_t         saved_next;
    logic              pending_reg;
    logic              pending_next;
    flags_t            flags_reg;
    flags_t            flags_next;

    // result stage
    logic              out_valid_reg;
    logic              cond_true_reg;
    logic              cond_true_next;
    flags_t            out_flags_reg;

    logic              advance;
    logic              accept;
    flags_t            derived;
    cond_grp_t         cond_grp;
    logic              cond_raw;
    logic              store_go;
    logic              eval_go;

    assign advance   = in_valid_reg & (~out_valid_reg | rsp_ready);
    assign req_ready = ~in_valid_reg | advance;
    assign accept    = req_valid & req_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg      <= req_type_t'(req_type);
            req_op_reg.result <= op_result;
            req_op_reg.first  <= first_source;
            req_op_reg.second <= second_source;
            req_op_reg.kind   <= op_kind;
            cond_code_reg     <= cond_code;
        end
    end

    // flag derivation from the recorded operation
    lxfe_flag_calc u_flag_calc (
        .op    (saved_reg),
        .flags (derived)
    );

    // state update and condition test
    always_comb
    begin
        saved_next     = saved_reg;
        pending_next   = pending_reg;
        flags_next     = flags_reg;
        cond_true_next = 1'b0;
        unique case (req_type_reg)
            REQ_STORE:
            begin
                saved_next   = req_op_reg;
                pending_next = 1'b1;
            end
            REQ_COND, REQ_FLAGS:
            begin
                if (pending_reg)
                begin
                    flags_next = derived;
                end
                pending_next = 1'b0;
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase
        if (req_type_reg == REQ_COND)
        begin
            cond_true_next = cond_raw ^ cond_code_reg[0];
        end
    end

    // condition test against the flags as they stand after derivation
    assign cond_grp = cond_grp_t'(cond_code_reg[COND_W-1:1]);

    always_comb
    begin
        unique case (cond_grp)
            CC_O:    cond_raw = flags_next.of;
            CC_B:    cond_raw = flags_next.cf;
            CC_Z:    cond_raw = flags_next.zf;
            CC_BE:   cond_raw = flags_next.cf | flags_next.zf;
            CC_S:    cond_raw = flags_next.sf;
            CC_P:    cond_raw = flags_next.pf;
            CC_L:    cond_raw = flags_next.sf ^ flags_next.of;
            default: cond_raw = flags_next.zf | (flags_next.sf ^ flags_next.of);
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            flags_reg   <= '0;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            flags_reg   <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            saved_reg <= saved_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (~out_valid_reg | rsp_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cond_true_reg <= cond_true_next;
            out_flags_reg <= flags_next;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign cond_true     = cond_true_reg;
    assign carry_flag    = out_flags_reg.cf;
    assign parity_flag   = out_flags_reg.pf;
    assign adjust_flag   = out_flags_reg.af;
    assign zero_flag     = out_flags_reg.zf;
    assign sign_flag     = out_flags_reg.sf;
    assign overflow_flag = out_flags_reg.of;

    // request kinds leaving the input stage
    assign store_go = advance & (req_type_reg == REQ_STORE);
    assign eval_go  = advance & ((req_type_reg == REQ_COND) | (req_type_reg == REQ_FLAGS));

    // a store marks the flags pending and leaves the held flags alone
    `ASSERT_CLK(a_store_pending, clk, rst_n, store_go |=> pending_reg)
    `ASSERT_CLK(a_store_keeps_flags, clk, rst_n, store_go |=> $stable(flags_reg))
    // any evaluation leaves nothing pending
    `ASSERT_CLK(a_eval_clears, clk, rst_n, eval_go |=> !pending_reg)
    // only condition requests can report a true condition
    `ASSERT_CLK(a_cond_only, clk, rst_n, (advance && req_type_reg != REQ_COND) |=> !cond_true_reg)
    // a stalled request in the input stage is never dropped
    `ASSERT_CLK(a_hold_input, clk, rst_n, (in_valid_reg && !advance) |=> in_valid_reg)

endmodule
